// ----- rtl/core/ksv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KSV lookup package
// Shared types, operation codes and helpers for the revocation lookup block.
// ----------------------------------------------------------------------------
package ksv_pkg;

    localparam int KEY_W           = 40;
    localparam int COUNT_OUT_W     = 9;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] entry_key;
        logic [KEY_W-1:0] lookup_key;
    } req_t;

    typedef struct packed {
        logic                   revoked;
        logic                   status;
        logic [COUNT_OUT_W-1:0] stored_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Reverse the five bytes of a key.
    function automatic logic [KEY_W-1:0] swap_key_bytes(input logic [KEY_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24], v[39:32]};
    endfunction

endpackage

// ----- rtl/core/ksv_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KSV key store
// Single-write, single-read table of revoked keys with registered read data.
// ----------------------------------------------------------------------------
module ksv_key_store
    import ksv_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int AW          = 8
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_key,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_key
);

    logic [KEY_W-1:0] mem [MAX_ENTRIES];
    logic [KEY_W-1:0] rd_key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_key;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;

endmodule

// ----- rtl/core/ksv_revocation_lookup.sv -----
`timescale 1ns / 1ps
// Requests are taken in idle only. A clear, append or unused-code request moves to the
// done state, which loads the result into the output register once it is free; a lookup
// over N > 0 stored entries first passes the scan and drain states, one table read per
// cycle through the single read port of the key store and one shared comparator. A
// finished result may wait in the output register while the next request is taken.
// Reset (rst_n, async, active low) empties the table; key storage is not cleared.
// ----------------------------------------------------------------------------
// KSV revocation lookup
// Revoked-key table with clear, append and linear-scan lookup.
// ----------------------------------------------------------------------------
module ksv_revocation_lookup
    import ksv_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Table address and entry count widths; count must hold MAX_ENTRIES.
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             rdv_reg, rdv_next;     // read data valid for compare
    logic             hit_reg, hit_next;
    logic             status_reg, status_next;
    logic [KEY_W-1:0] key_reg, key_next;     // key under lookup
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             req_fire;
    logic             rsp_free;
    logic             wr_en;
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic [AW-1:0]    last_idx;
    logic             table_full;

    assign req_fire   = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign table_full = (count_reg >= CW'(MAX_ENTRIES));
    assign last_idx   = AW'(count_reg - 1'b1);

    // Append writes at the current count during the request transfer, unless the table is full.
    assign wr_en = req_fire && (req.operation == OP_APPEND) && !table_full;

    ksv_key_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(count_reg)),
        .wr_key  (req.entry_key),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_key  (rd_key)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_LOOKUP && count_reg != '0)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == last_idx)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        req_stall      = 1'b1;
        rd_en          = 1'b0;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        key_next       = key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        rdv_next       = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        // Shared comparator: one stored entry per cycle, bytes reversed.
        if (rdv_reg && (swap_key_bytes(rd_key) == key_reg))
            hit_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                    idx_next    = '0;
                    key_next    = req.lookup_key;
                    case (req.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (table_full)
                                status_next = 1'b1;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en    = 1'b1;
                rdv_next = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.revoked      = hit_reg;
                    rsp_next.status       = status_reg;
                    rsp_next.stored_count = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rdv_reg       <= rdv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("scan started on empty table");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.operation == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty table");

    a_rsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.revoked && rsp_reg.status))
        else $error("revoked and full flag both set");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.operation == OP_APPEND && table_full) |=> $stable(count_reg))
        else $error("append to full table changed count");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KSV revocation lookup testbench
// Drives clear, append, lookup and unused-code requests into the revoked-key
// table. A local mirror of the table predicts each verdict, and every
// response transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import ksv_pkg::*;

    // The package has no name for the fourth operation code; the block must
    // answer it with the current count and change nothing.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         MAX_ENTRIES = MAX_ENTRIES_DEF;
    // Drain time for the longest lookup, a scan of a full table; stalls stretch that a lot.
    localparam int         DRAIN_CYCLES   = MAX_ENTRIES + 44;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         MAX_PRINTED    = 50;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Mirror of the block state, updated at each request transfer.
    logic [KEY_W-1:0] mirror_keys [MAX_ENTRIES];
    int               mirror_count = 0;

    // Verdicts predicted for accepted requests, oldest first.
    rsp_t pending_verdicts [$];

    // Idling knobs, in percent, changed per phase.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    int error_count     = 0;
    int items_sent      = 0;
    int lookups_sent    = 0;
    int hits_seen       = 0;
    int drops_seen      = 0;
    int verdicts_seen   = 0;
    int quiet_cycles    = 0;

    ksv_revocation_lookup #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------------

    // Stored entries keep list byte 0 low; a device key matches the entry
    // with its five bytes in the opposite order.
    function automatic logic [KEY_W-1:0] reverse_key_bytes(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < 5; b++)
        begin
            r[8*(4-b) +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic rsp_t predict_verdict(input req_t item);
        rsp_t v;
        v = '0;
        case (item.operation)
            OP_CLEAR:
            begin
                // old entries stay in storage but are no longer searched
                mirror_count = 0;
            end
            OP_APPEND:
            begin
                if (mirror_count < MAX_ENTRIES)
                begin
                    mirror_keys[mirror_count] = item.entry_key;
                    mirror_count++;
                end
                else
                begin
                    v.status = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                for (int i = 0; i < mirror_count; i++)
                begin
                    if (reverse_key_bytes(mirror_keys[i]) == item.lookup_key)
                    begin
                        v.revoked = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        v.stored_count = COUNT_OUT_W'(mirror_count);
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {8'($urandom_range(255)), 32'($urandom())};
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Drives one request and returns at the edge where it transfers. Valid
    // is left high so a back-to-back request never toggles it in one step.
    task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] entry,
                                input logic [KEY_W-1:0] lookup);
        req_t item;
        rsp_t v;
        item.operation  = op;
        item.entry_key  = entry;
        item.lookup_key = lookup;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        v = predict_verdict(item);
        pending_verdicts = {pending_verdicts, v};
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
        if (op == OP_LOOKUP)
        begin
            lookups_sent++;
            hits_seen += v.revoked;
        end
        drops_seen += v.status;
    endtask

    // Hold off until every outstanding verdict is back. Always lowers valid and waits on
    // the clock before checking, so valid is never lowered and raised in one step.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Lookup of a stored key, a stored key with one bit flipped, or noise.
    task automatic send_probe();
        logic [KEY_W-1:0] key;
        int               pick;
        int               bit_pos;
        key  = rand_key();
        pick = $urandom_range(9);
        if (mirror_count > 0 && pick < 7)
        begin
            key = reverse_key_bytes(mirror_keys[$urandom_range(mirror_count - 1)]);
            if (pick == 6)
            begin
                bit_pos      = $urandom_range(KEY_W - 1);
                key[bit_pos] = ~key[bit_pos];
            end
        end
        send_request(OP_LOOKUP, rand_key(), key);
    endtask

    // Appends random keys until the table is full, then pushes extra more appends.
    task automatic fill_table(input int extra);
        while (mirror_count < MAX_ENTRIES)
        begin
            send_request(OP_APPEND, rand_key(), rand_key());
        end
        repeat (extra)
        begin
            send_request(OP_APPEND, rand_key(), rand_key());
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall, then check each transfer in order
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
        begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
        error_count++;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("response with nothing outstanding: %p", rsp));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp.revoked !== want.revoked || rsp.status !== want.status ||
                    rsp.stored_count !== want.stored_count)
                begin
                    report_mismatch($sformatf(
                        "verdict %0d: revoked %b/%b status %b/%b count %0d/%0d (got/want)",
                        verdicts_seen, rsp.revoked, want.revoked, rsp.status, want.status,
                        rsp.stored_count, want.stored_count));
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // Watchdog: a long stretch with no transfer on either side is a hang.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Lookups and the unused code against a table that has never held a key.
    task automatic test_empty_table();
        send_request(OP_LOOKUP, rand_key(), '0);
        send_request(OP_LOOKUP, rand_key(), '1);
        send_request(OP_UNUSED, '1, '1);
    endtask

    // Byte-order match, extreme keys and duplicate entries.
    task automatic test_append_lookup();
        send_request(OP_APPEND, '0, rand_key());
        send_request(OP_APPEND, '1, rand_key());
        send_request(OP_APPEND, 40'h01_02_03_04_05, rand_key());
        send_request(OP_APPEND, 40'h01_02_03_04_05, rand_key());
        send_request(OP_APPEND, 40'h80_00_00_00_7f, rand_key());
        send_request(OP_LOOKUP, rand_key(), '0);
        send_request(OP_LOOKUP, rand_key(), '1);
        // reversed bytes hit, the stored order itself must miss
        send_request(OP_LOOKUP, rand_key(), 40'h05_04_03_02_01);
        send_request(OP_LOOKUP, rand_key(), 40'h01_02_03_04_05);
        send_request(OP_LOOKUP, rand_key(), 40'h7f_00_00_00_80);
        send_request(OP_LOOKUP, rand_key(), 40'h80_00_00_00_7f);
        send_request(OP_UNUSED, rand_key(), rand_key());
    endtask

    // After a clear the stale entries must not be found.
    task automatic test_clear();
        wait_drained();
        send_request(OP_CLEAR, '1, '1);
        send_request(OP_LOOKUP, rand_key(), 40'h05_04_03_02_01);
        send_request(OP_LOOKUP, rand_key(), '0);
        send_request(OP_APPEND, 40'h11_22_33_44_55, rand_key());
        send_request(OP_LOOKUP, rand_key(), 40'h55_44_33_22_11);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // Full table: dropped appends, hits at both ends, count at its top.
    task automatic test_full_table();
        send_request(OP_APPEND, 40'hfe_dc_ba_98_76, rand_key());
        fill_table(2);
        send_request(OP_LOOKUP, rand_key(), 40'h76_98_ba_dc_fe);
        send_request(OP_LOOKUP, rand_key(), reverse_key_bytes(mirror_keys[MAX_ENTRIES-1]));
        send_probe();
        send_request(OP_UNUSED, rand_key(), rand_key());
        send_request(OP_CLEAR, rand_key(), rand_key());
    endtask

    // Mostly well-formed sessions (optional clear, a few appends, probes),
    // mixed with lone clears, lone appends, unused codes, stray lookups and rare table fills.
    task automatic test_random_traffic(input int quota);
        int target;
        int r;
        int k;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            r = $urandom_range(199);
            if (r < 16)
            begin
                send_request(OP_CLEAR, rand_key(), rand_key());
            end
            else if (r < 140)
            begin
                if ($urandom_range(1) == 1)
                begin
                    send_request(OP_CLEAR, rand_key(), rand_key());
                end
                k = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
                repeat (k)
                begin
                    send_request(OP_APPEND, rand_key(), rand_key());
                end
                repeat ($urandom_range(6, 1))
                begin
                    send_probe();
                end
            end
            else if (r < 170)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_request(OP_APPEND, rand_key(), rand_key());
                end
            end
            else if (r < 184)
            begin
                send_request(OP_UNUSED, rand_key(), rand_key());
            end
            else if (r < 199)
            begin
                send_probe();
            end
            else
            begin
                fill_table($urandom_range(2));
                repeat ($urandom_range(3, 1))
                begin
                    send_probe();
                end
                send_request(OP_CLEAR, rand_key(), rand_key());
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 0;
        rsp_stall_pct = 0;
        test_empty_table();
        test_append_lookup();
        test_clear();
        test_full_table();
        wait_drained();

        test_random_traffic(180);
        send_idle_pct = 78;
        rsp_stall_pct = 0;
        test_random_traffic(180);
        send_idle_pct = 0;
        rsp_stall_pct = 78;
        test_random_traffic(180);
        send_idle_pct = 23;
        rsp_stall_pct = 23;
        test_random_traffic(180);

        // Let any stray response show up before the verdict.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d lookups, %0d hits, %0d dropped appends)",
                 items_sent, lookups_sent, hits_seen, drops_seen);
        $display("Checked %0d responses over four idle/stall mixes, %0d mismatches",
                 verdicts_seen, error_count);
        if (error_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ksv_pkg.sv
rtl/core/ksv_key_store.sv
rtl/core/ksv_revocation_lookup.sv
dv/tb_top.sv
